[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
// Each macro places one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ple_pkg.sv]
// Shared types and codes for the positional list engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ple_pkg;

  // Action codes of the input word
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_END   = 3'd1;
  localparam logic [2:0] ACT_INS_POS   = 3'd2;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [2:0] ACT_DEL_POS   = 3'd4;
  localparam logic [2:0] ACT_DEL_END   = 3'd5;
  localparam logic [2:0] ACT_READ_ALL  = 3'd6;

  // Status codes of the result word
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_res;
    logic [3:0]         index;
    logic               last;
  } ple_out_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;      // apply a single-result action and load its result
    logic rd_start;  // clear the read counter for a read-all pass
    logic rd_step;   // emit the front cell and rotate the list by one
  } ple_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;   // output register is empty or being taken
    logic list_empty;  // length is zero
    logic rd_last;     // read counter is at the final element
  } ple_stat_t;

endpackage

[hw/rtl/positional_list_engine.sv]
// Top level of the positional list engine: joins controller and datapath.
// Depends on ple_pkg, ple_controller and ple_datapath.
//
// Usage:
//   in_*  : one word per action (insert front/end/position, delete
//           front/position/end, read all), valid/ready handshake.
//   out_* : result words, valid/ready handshake; last marks the final
//           word caused by one input word.
//   Insert and delete actions update the shifting cell store in the
//   cycle the word is accepted; the result shows in the cycle after. A new
//   word is taken every cycle while results are drained, so these actions
//   run at one word per cycle.
//   Read all starts its pass when the word is accepted, then sends one
//   word per element, each element rotated out of the front cell.
//   No word is accepted during that pass. An empty list gives one word.
//   Reset empties the list and drops any pending result; no clearing pass.
//   When the receiver stalls, the output register holds its word and the
//   input side stops taking words until that word is taken.
`timescale 1ns / 1ps

module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);
  import ple_pkg::*;

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/ple_datapath.sv]
// Datapath of the positional list engine: shifting cell store, length count,
// read counter and output register. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ple_pkg::ple_in_t  in_data,
  input  ple_pkg::ple_cmd_t cmd,
  output ple_pkg::ple_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output ple_pkg::ple_out_t out_data
);
  import ple_pkg::*;

  localparam int LW    = $clog2(CAPACITY + 1);
  localparam int IW    = $clog2(CAPACITY);
  localparam int CMP_W = (LW > 5) ? LW : 5;

  logic signed [31:0] cells_r   [CAPACITY];
  logic signed [31:0] cells_nxt [CAPACITY];
  logic [LW-1:0]      length_r, length_nxt;
  logic [IW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  ple_out_t           out_data_r, out_data_nxt;

  logic [4:0]    pos_eff;
  logic          pos_over;
  logic          full, empty;
  logic          do_ins, do_del;
  logic [IW-1:0] slot;
  logic [1:0]    exec_status;
  logic [IW+3:0] idx_ext;

  // Decode the action against the current length
  assign pos_eff  = (in_data.position == 5'd0) ? 5'd1 : in_data.position;
  assign pos_over = CMP_W'(pos_eff) > CMP_W'(length_r);
  assign full     = (length_r == LW'(CAPACITY));
  assign empty    = (length_r == '0);

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    slot        = '0;
    exec_status = STAT_OK;
    case (in_data.action)
      ACT_INS_FRONT: begin
        if (full) exec_status = STAT_FULL;
        else do_ins = 1'b1;
      end
      ACT_INS_END: begin
        slot = IW'(length_r);
        if (full) exec_status = STAT_FULL;
        else do_ins = 1'b1;
      end
      ACT_INS_POS: begin
        slot = IW'(pos_eff - 5'd1);
        if (full) exec_status = STAT_FULL;
        else if (pos_over) exec_status = STAT_RANGE;
        else do_ins = 1'b1;
      end
      ACT_DEL_FRONT: begin
        if (empty) exec_status = STAT_EMPTY;
        else do_del = 1'b1;
      end
      ACT_DEL_POS: begin
        slot = IW'(pos_eff - 5'd1);
        if (empty) exec_status = STAT_EMPTY;
        else if (pos_over) exec_status = STAT_RANGE;
        else do_del = 1'b1;
      end
      ACT_DEL_END: begin
        slot = IW'(length_r - LW'(1));
        if (empty) exec_status = STAT_EMPTY;
        else do_del = 1'b1;
      end
      ACT_READ_ALL: begin
        if (empty) exec_status = STAT_EMPTY;
      end
      default: ;
    endcase
  end

  // Each cell takes its own value, a neighbor, the new word or the front cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (cmd.exec && do_ins) begin
        if (i > int'(slot)) cells_nxt[i] = cells_r[(i == 0) ? 0 : i - 1];
        else if (i == int'(slot)) cells_nxt[i] = in_data.value;
      end else if (cmd.exec && do_del) begin
        if (i >= int'(slot) && i < CAPACITY - 1) cells_nxt[i] = cells_r[i + 1];
      end else if (cmd.rd_step) begin
        if (i + 1 < int'(length_r)) cells_nxt[i] = cells_r[(i == CAPACITY - 1) ? i : i + 1];
        else if (i + 1 == int'(length_r)) cells_nxt[i] = cells_r[0];
      end
    end
  end

  // Track length and read position
  always_comb begin
    length_nxt = length_r;
    if (cmd.exec && do_ins) length_nxt = length_r + LW'(1);
    else if (cmd.exec && do_del) length_nxt = length_r - LW'(1);
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (cmd.rd_start) rd_cnt_nxt = '0;
    else if (cmd.rd_step) rd_cnt_nxt = rd_cnt_r + IW'(1);
  end

  assign stat.rd_last    = (LW'(rd_cnt_r) + LW'(1) == length_r);
  assign stat.list_empty = empty;
  assign stat.slot_free  = !out_valid_r || out_ready;

  // Load the output register with a single result or one read-all word
  assign idx_ext = {4'b0000, rd_cnt_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.exec) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = exec_status;
      out_data_nxt.value_res = '0;
      out_data_nxt.index     = '0;
      out_data_nxt.last      = 1'b1;
    end else if (cmd.rd_step) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = STAT_OK;
      out_data_nxt.value_res = cells_r[0];
      out_data_nxt.index     = idx_ext[3:0];
      out_data_nxt.last      = stat.rd_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      length_r    <= length_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Store and result payload carry no reset
  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/ple_controller.sv]
// Controller of the positional list engine: accepts words and sequences
// read-all passes. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_cmd_t  cmd
);
  import ple_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic accept, is_read, read_pass;

  // Take a word only while idle and the result slot can be refilled
  assign in_ready  = (state_r == S_IDLE) && stat.slot_free;
  assign accept    = in_valid && in_ready;
  assign is_read   = (in_action == ACT_READ_ALL);
  assign read_pass = is_read && !stat.list_empty;

  assign cmd.exec     = accept && !read_pass;
  assign cmd.rd_start = accept && read_pass;
  assign cmd.rd_step  = (state_r == S_READ) && stat.slot_free;

  // Advance through the list one element per free result slot
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.rd_start) state_nxt = S_READ;
      end
      S_READ: begin
        if (cmd.rd_step && stat.rd_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/ple_checker.sv]
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ple_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ple_pkg::ple_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ple_pkg::ple_out_t out_data
);
  import ple_pkg::*;

  // Hold an offered input word until it is taken
  `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
            in_valid && $stable(in_data), "input word changed while waiting")

  // Hold a stalled result word
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped")

  // No new word is taken while a read-all pass still has words to send
  `CHK_SAME(a_no_accept_mid_read, clk, rst_n, out_valid && out_ready && !out_data.last,
            !in_ready, "input taken during read-all pass")

  // Only read-all element words may be non-final, and they report ok
  `CHK_SAME(a_nonlast_ok, clk, rst_n, out_valid && !out_data.last,
            out_data.status == STAT_OK, "non-final word with error status")

  // Error results are single words with zero payload
  `CHK_SAME(a_err_clean, clk, rst_n, out_valid && out_data.status != STAT_OK,
            out_data.last && out_data.value_res == 0 && out_data.index == 0,
            "error word malformed")

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
